// ===== src/ghist_pkg.sv =====
// Shared types, constants and helpers for the grey-level histogram.
package ghist_pkg;

  localparam int unsigned NumBins = 256;
  localparam int unsigned IdxW    = $clog2(NumBins);
  localparam int unsigned CountW  = 24;
  localparam int unsigned PixW    = 8;
  localparam int unsigned ActW    = 2;

  localparam logic [PixW-1:0] WhitePixel = 8'hFF;

  typedef logic [CountW-1:0] count_t;
  typedef logic [IdxW-1:0]   idx_t;
  typedef logic [PixW-1:0]   pix_t;

  typedef enum logic [ActW-1:0] {
    ACT_ADD   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_QUERY = 2'd2
  } action_e;

  // bin table request for one cycle
  typedef struct packed {
    logic rd_en;
    idx_t rd_idx;
    logic wr_en;
    idx_t wr_idx;
    logic clr;
  } bin_req_t;

  // running statistics request
  typedef struct packed {
    logic add;
    logic clr;
  } stat_req_t;

  function automatic count_t sat_inc(input count_t x);
    count_t r;
    if (x == {CountW{1'b1}}) begin
      r = x;
    end else begin
      r = x + count_t'(1);
    end
    return r;
  endfunction

endpackage

// ===== src/ghist_bin_store.sv =====
// Bin count memory with registered read and per-entry valid bits, so that one clear request empties all entries.
module ghist_bin_store (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ghist_pkg::bin_req_t req_i,
  input  ghist_pkg::count_t   wr_data_i,
  output ghist_pkg::count_t   rd_data_o
);
  import ghist_pkg::*;

  count_t               mem [NumBins];
  logic [NumBins-1:0]   valid_q;
  count_t               rd_q;
  logic                 rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_idx] <= wr_data_i;
    end
    if (req_i.rd_en) begin
      rd_q <= mem[req_i.rd_idx];
    end
  end

  // an entry not written since reset or clear reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.clr) begin
        valid_q <= '0;
      end else if (req_i.wr_en) begin
        valid_q[req_i.wr_idx] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= valid_q[req_i.rd_idx];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

// ===== src/ghist_stats.sv =====
// Saturating pixel total and running peak bin count.
module ghist_stats (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ghist_pkg::stat_req_t req_i,
  input  ghist_pkg::count_t    bin_new_i,
  output ghist_pkg::count_t    total_o,
  output ghist_pkg::count_t    peak_o
);
  import ghist_pkg::*;

  count_t total_q, total_d;
  count_t peak_q, peak_d;

  always_comb begin
    total_d = total_q;
    peak_d  = peak_q;
    if (req_i.clr) begin
      total_d = '0;
      peak_d  = '0;
    end else if (req_i.add) begin
      total_d = sat_inc(total_q);
      if (bin_new_i > peak_q) begin
        peak_d = bin_new_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      peak_q  <= '0;
    end else begin
      total_q <= total_d;
      peak_q  <= peak_d;
    end
  end

  // values after the current step
  assign total_o = total_d;
  assign peak_o  = peak_d;

endmodule

// ===== src/grey_level_histogram.sv =====
// Grey-level histogram engine: top level with sequencer and output register.
//
// Input words (s_axis): tuser carries the action (add, clear, query; code
// three acts as a query), tdata the pixel value or bin index and the chart
// row level. Each accepted word yields exactly one result word on m_axis:
// the bin count after the step, the saturating pixel total, the peak bin
// count and the chart pixel (bar grey when the count reaches the row level,
// else white). cfg_we_i writes the bar grey; the user is to write it only
// while idle, as the block itself does not enforce this. An accepted word
// starts a read-modify-write of the bin memory: the registered read, then
// update and write back in the calc state; its result is then presented
// from the output register on m_axis. No new word is taken until the
// previous one has left the memory loop. A clear empties all bins together
// through per-bin valid bits. Reset empties the histogram and sets bar grey
// to zero; no clearing pass. While m_axis is stalled the result holds and
// a further word is accepted only as the output register drains.
module grey_level_histogram (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,     // bar_grey
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,    // value[7:0], row_level[31:8]
  input  logic [1:0]  s_axis_tuser,    // action[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata     // bin_count[23:0], total_count[47:24],
                                       // max_count[71:48], chart_pixel[79:72]
);
  import ghist_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_CALC = 2'b10
  } state_e;

  state_e    state_q, state_d;
  logic      accept;
  pix_t      bar_grey_q;

  logic [ActW-1:0] act_q;
  idx_t            idx_q;
  count_t          lvl_q;

  bin_req_t  bin_req;
  stat_req_t stat_req;
  count_t    bin_cur, bin_new, bin_cnt, total, peak;
  pix_t      chart;
  logic      is_add, is_clr, in_calc;

  logic      out_valid_q, out_valid_d;
  count_t    out_bin_q, out_total_q, out_peak_q;
  pix_t      out_pix_q;

  assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_calc       = (state_q == ST_CALC);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_CALC;
      ST_CALC: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      bar_grey_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        bar_grey_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q <= s_axis_tuser;
      idx_q <= s_axis_tdata[IdxW-1:0];
      lvl_q <= s_axis_tdata[PixW +: CountW];
    end
  end

  assign is_add  = in_calc && (act_q == ACT_ADD);
  assign is_clr  = in_calc && (act_q == ACT_CLEAR);
  assign bin_new = sat_inc(bin_cur);

  always_comb begin
    case (act_q)
      ACT_ADD:   bin_cnt = bin_new;
      ACT_CLEAR: bin_cnt = '0;
      default:   bin_cnt = bin_cur;
    endcase
  end

  assign chart = (bin_cnt >= lvl_q) ? bar_grey_q : WhitePixel;

  always_comb begin
    bin_req.rd_en  = accept;
    bin_req.rd_idx = s_axis_tdata[IdxW-1:0];
    bin_req.wr_en  = is_add;
    bin_req.wr_idx = idx_q;
    bin_req.clr    = is_clr;
    stat_req.add   = is_add;
    stat_req.clr   = is_clr;
  end

  ghist_bin_store u_bins (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (bin_req),
    .wr_data_i (bin_new),
    .rd_data_o (bin_cur)
  );

  ghist_stats u_stats (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (stat_req),
    .bin_new_i (bin_new),
    .total_o   (total),
    .peak_o    (peak)
  );

  // output word register
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_calc) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_calc) begin
      out_bin_q   <= bin_cnt;
      out_total_q <= total;
      out_peak_q  <= peak;
      out_pix_q   <= chart;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_pix_q, out_peak_q, out_total_q, out_bin_q};

`ifndef SYNTH
  a_calc_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CALC |=> state_q == ST_IDLE)
    else $error("update stage held for more than one cycle");

  a_accept_to_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_CALC)
    else $error("accepted word did not reach update stage");

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CALC |-> !out_valid_q)
    else $error("result overwrites an untaken word");

  a_peak_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_peak_q >= out_bin_q)
    else $error("peak below reported bin count");
`endif

endmodule
